### design/xcpd_pkg.sv
`default_nettype none
package xcpd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned VALUE_W  = 16;

  localparam logic [BYTE_W-1:0] START_BYTE = 8'hAA;
  localparam logic [BYTE_W-1:0] MIN_LENGTH = 8'd4;

  // frame positions, counted from the start byte
  localparam logic [BYTE_W-1:0] POS_HUNT    = 8'd0;
  localparam logic [BYTE_W-1:0] POS_LENGTH  = 8'd1;
  localparam logic [BYTE_W-1:0] POS_COMMAND = 8'd2;
  localparam logic [BYTE_W-1:0] POS_HIGH    = 8'd3;
  localparam logic [BYTE_W-1:0] POS_LOW     = 8'd4;

  typedef struct packed {
    logic [VALUE_W-1:0] sample_value;
    logic [BYTE_W-1:0]  command_byte;
    logic [BYTE_W-1:0]  frame_length;
  } frame_data_t;

endpackage
`default_nettype wire

### design/xor_checked_packet_deframer_unit.sv
// Deframer for length-prefixed packets with an xor checksum.
// Input stream: one received byte per word on s_tdata. The block hunts for
// start byte 0xaa, reads a length byte (total frame size, 4 to 255, start,
// length and checksum bytes included), then collects the rest of the frame.
// A length below four drops the frame silently and the hunt resumes.
// Output stream: one word per completed frame, carrying the length, the
// command byte (position 2) and the 16-bit value from positions 3 and 4;
// m_tuser flags whether the last byte matched the xor of all earlier bytes.
// Frames with a bad checksum are still delivered.
// The result word appears on m_tvalid in the cycle after the final checksum
// byte is accepted. One input byte per cycle is taken while s_tready is high,
// set by the single registered update of the frame tracker and the output register.
// A stalled receiver holds the output word; s_tready stays high as long as
// the output register is empty or is being emptied in the same cycle, so
// any input byte stalls while a finished frame waits on a stalled receiver.
// Reset (rst, synchronous) returns the block to hunting and empties the
// output register.
`default_nettype none
module xor_checked_packet_deframer_unit
  import xcpd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [7:0] frame_length, [15:8] command_byte,
                                      // [31:16] sample_value
  output logic [0:0]       m_tuser    // [0] checksum_ok
);

  logic [BYTE_W-1:0] byte_position, byte_position_next;
  logic [BYTE_W-1:0] expected_length, expected_length_next;
  logic [BYTE_W-1:0] running_xor, running_xor_next;
  logic [BYTE_W-1:0] held_command, held_command_next;
  logic [BYTE_W-1:0] held_value_high, held_value_high_next;
  logic [BYTE_W-1:0] held_value_low, held_value_low_next;

  frame_data_t result, result_next;
  logic        result_ok, result_ok_next;
  logic        frame_done;
  logic        accept;
  logic [BYTE_W:0] pos_plus_one;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign pos_plus_one = {1'b0, byte_position} + {{BYTE_W{1'b0}}, 1'b1};

  always_comb begin
    byte_position_next   = byte_position;
    expected_length_next = expected_length;
    running_xor_next     = running_xor;
    held_command_next    = held_command;
    held_value_high_next = held_value_high;
    held_value_low_next  = held_value_low;
    frame_done           = 1'b0;

    if (byte_position == POS_HUNT) begin
      if (s_tdata == START_BYTE) begin
        running_xor_next   = s_tdata;
        byte_position_next = POS_LENGTH;
      end
    end else if (byte_position == POS_LENGTH) begin
      if (s_tdata < MIN_LENGTH) begin
        byte_position_next = POS_HUNT;
        running_xor_next   = '0;
      end else begin
        expected_length_next = s_tdata;
        running_xor_next     = running_xor ^ s_tdata;
        held_command_next    = '0;
        held_value_high_next = '0;
        held_value_low_next  = '0;
        byte_position_next   = POS_COMMAND;
      end
    end else begin
      if (byte_position == POS_COMMAND) held_command_next    = s_tdata;
      if (byte_position == POS_HIGH)    held_value_high_next = s_tdata;
      if (byte_position == POS_LOW)     held_value_low_next  = s_tdata;
      // last byte of the frame is the checksum
      if (pos_plus_one >= {1'b0, expected_length}) begin
        frame_done         = 1'b1;
        byte_position_next = POS_HUNT;
        running_xor_next   = '0;
      end else begin
        running_xor_next   = running_xor ^ s_tdata;
        byte_position_next = pos_plus_one[BYTE_W-1:0];
      end
    end

    result_next.frame_length = expected_length;
    result_next.command_byte = held_command_next;
    result_next.sample_value = {held_value_high_next, held_value_low_next};
    result_ok_next           = (s_tdata == running_xor);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= POS_HUNT;
      expected_length <= '0;
      running_xor     <= '0;
      held_command    <= '0;
      held_value_high <= '0;
      held_value_low  <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      if (accept) begin
        byte_position   <= byte_position_next;
        expected_length <= expected_length_next;
        running_xor     <= running_xor_next;
        held_command    <= held_command_next;
        held_value_high <= held_value_high_next;
        held_value_low  <= held_value_low_next;
      end
      if (accept && frame_done) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // output payload, loaded only when a frame completes
  always_ff @(posedge clk) begin
    if (accept && frame_done) begin
      result    <= result_next;
      result_ok <= result_ok_next;
    end
  end

  assign m_tdata    = result;
  assign m_tuser[0] = result_ok;

endmodule
`default_nettype wire
